@@ design/gbiw_pkg.sv @@
// ----------------------------------------------------------------------------
// gbiw_pkg
// shared widths, codes and types for the grid bracket interpolation weights
// block
// ----------------------------------------------------------------------------
package gbiw_pkg;

    localparam int VALUE_W       = 32;
    localparam int GRID_INDEX_W  = 6;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int POINT_COUNT_W = 7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SUM_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT = 1'd1;

    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [GRID_INDEX_W-1:0]    grid_index_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

endpackage

@@ design/gbiw_if.sv @@
// ----------------------------------------------------------------------------
// gbiw_if
// valid/ready channels for request words and response words
// ----------------------------------------------------------------------------
interface gbiw_req_if;
    import gbiw_pkg::*;

    logic        valid;
    logic        ready;
    logic        command;
    grid_index_t grid_index;
    value_t      grid_value;
    value_t      first_value;
    value_t      second_value;

    modport source (
        output valid, command, grid_index, grid_value, first_value, second_value,
        input  ready
    );
    modport sink (
        input  valid, command, grid_index, grid_value, first_value, second_value,
        output ready
    );
endinterface

interface gbiw_rsp_if;
    import gbiw_pkg::*;

    logic        valid;
    logic        ready;
    grid_index_t lower_index;
    grid_index_t upper_index;
    value_t      lower_weight;
    value_t      upper_weight;
    logic        bad_grid;

    modport source (
        output valid, lower_index, upper_index, lower_weight, upper_weight, bad_grid,
        input  ready
    );
    modport sink (
        input  valid, lower_index, upper_index, lower_weight, upper_weight, bad_grid,
        output ready
    );
endinterface

@@ design/grid_bracket_interpolation_weights.sv @@
// ----------------------------------------------------------------------------
// grid_bracket_interpolation_weights
// bracket search over a loaded grid and signed Q16.16 interpolation weights
// ----------------------------------------------------------------------------
// request carries one word per item: a load writes grid_value at grid_index
// (indices at or above GRID_DEPTH are dropped), a query brings first_value
// and second_value. the target is their sum or their absolute difference,
// per sum_mode. a query returns one response word: the bracketing indices,
// both weights saturated to 32 bits, and bad_grid when the two bracketing
// points are equal (weights zero). a load gives no response word.
// a load leaves request ready for the next word. a query scans point_count
// entries clamped to [2, GRID_DEPTH], one grid memory read per cycle, then,
// when bad_grid is clear, one restoring divider makes one quotient bit per
// cycle, used once for each weight. request is not ready during a query.
// the response sits in an output register; if the receiver stalls, a
// finished query waits until that register frees up, and request stays low.
// reset sets sum_mode to 1 and point_count to 64; grid contents are
// undefined until loaded. config is sampled when a query is accepted.
// ----------------------------------------------------------------------------
module grid_bracket_interpolation_weights #(
    parameter int GRID_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gbiw_req_if.sink              request,
    gbiw_rsp_if.source            response,
    input  logic                  cfg_we,
    input  gbiw_pkg::cfg_index_t  cfg_index,
    input  gbiw_pkg::cfg_data_t   cfg_data
);
    import gbiw_pkg::*;

    localparam int IDX_W     = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int T_W       = VALUE_W + 2;
    localparam int NUM_W     = VALUE_W + 3;
    localparam int MAG_W     = VALUE_W + 1;
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = MAG_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(GRID_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_CLAMP,
        S_RD_M,
        S_RD_N,
        S_PREP,
        S_DIV
    } state_t;

    typedef logic signed [T_W-1:0]   target_t;
    typedef logic signed [NUM_W-1:0] num_t;

    function automatic logic [MAG_W-1:0] num_mag(input num_t v);
        num_t a;
        a = v[NUM_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic value_t saturate(input logic [DVD_W-1:0] q, input logic neg);
        value_t r;
        if (!neg) begin
            r = (|q[DVD_W-1:VALUE_W-1]) ? value_t'({1'b0, {(VALUE_W-1){1'b1}}})
                                        : value_t'({1'b0, q[VALUE_W-2:0]});
        end
        else begin
            r = ((|q[DVD_W-1:VALUE_W]) || (q[VALUE_W-1] && (|q[VALUE_W-2:0])))
                ? value_t'({1'b1, {(VALUE_W-1){1'b0}}})
                : -value_t'(q[VALUE_W-1:0]);
        end
        return r;
    endfunction

    // configuration
    logic                     sum_mode_reg;
    logic [POINT_COUNT_W-1:0] point_count_reg;

    // sequencer and datapath
    state_t              state_reg;
    target_t             t_reg;
    logic [IDX_W-1:0]    last_reg;
    logic [IDX_W-1:0]    k_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [IDX_W-1:0]    m_reg;
    logic [IDX_W-1:0]    n_reg;
    logic                found_reg;
    value_t              gm_reg;
    logic [VALUE_W-1:0]  den_mag_reg;
    logic                den_neg_reg;
    logic [VALUE_W-1:0]  rem_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic                qneg_reg;
    logic                phase_reg;
    logic [STEP_W-1:0]   step_reg;
    value_t              lw_reg;
    logic                done_pend_reg;

    // output register
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_m_reg;
    logic [IDX_W-1:0]    out_n_reg;
    value_t              out_lw_reg;
    value_t              out_uw_reg;
    logic                out_bad_reg;
    value_t              res_uw_reg;
    logic                res_bad_reg;

    // grid memory
    value_t              grid_mem [GRID_DEPTH];
    value_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;

    logic                in_fire;
    target_t             t_sum;
    target_t             t_diff;
    target_t             t_target;
    logic [IDX_W-1:0]    last_init;
    logic                hit_le;
    logic signed [MAG_W-1:0] den_c;
    num_t                num0;
    num_t                num1;
    logic [MAG_W-1:0]    rem_sh;
    logic                q_bit;
    logic [VALUE_W-1:0]  rem_next;
    logic [DVD_W-1:0]    dvd_next;
    value_t              q_sat;
    logic                out_free;

    assign request.ready = (state_reg == S_IDLE) && !done_pend_reg;
    assign in_fire       = request.valid && request.ready;
    assign out_free      = !out_valid_reg || response.ready;

    assign response.valid        = out_valid_reg;
    assign response.lower_index  = GRID_INDEX_W'(out_m_reg);
    assign response.upper_index  = GRID_INDEX_W'(out_n_reg);
    assign response.lower_weight = out_lw_reg;
    assign response.upper_weight = out_uw_reg;
    assign response.bad_grid     = out_bad_reg;

    always_comb
    begin
        t_sum    = T_W'(request.first_value) + T_W'(request.second_value);
        t_diff   = T_W'(request.first_value) - T_W'(request.second_value);
        t_target = sum_mode_reg ? t_sum : (t_diff[T_W-1] ? -t_diff : t_diff);

        if (point_count_reg < POINT_COUNT_W'(2)) begin
            last_init = IDX_ONE;
        end
        else if (int'(point_count_reg) > GRID_DEPTH) begin
            last_init = LAST_MAX;
        end
        else begin
            last_init = IDX_W'(point_count_reg - POINT_COUNT_W'(1));
        end

        mem_we = in_fire && (request.command == CMD_LOAD)
                 && (int'(request.grid_index) < GRID_DEPTH);

        case (state_reg)
            S_RD_M:  rd_addr = m_reg;
            S_RD_N:  rd_addr = n_reg;
            default: rd_addr = k_reg;
        endcase

        hit_le = T_W'(rd_data_reg) <= t_reg;
        den_c  = MAG_W'(gm_reg) - MAG_W'(rd_data_reg);
        num0   = NUM_W'(t_reg) - NUM_W'(rd_data_reg);
        num1   = NUM_W'(t_reg) - NUM_W'(gm_reg);

        // restoring divider, one quotient bit per cycle
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        q_bit    = rem_sh >= {1'b0, den_mag_reg};
        rem_next = q_bit ? VALUE_W'(rem_sh - {1'b0, den_mag_reg}) : rem_sh[VALUE_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
        q_sat    = saturate(dvd_next, qneg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            grid_mem[IDX_W'(request.grid_index)] <= request.grid_value;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_mode_reg    <= 1'b1;
            point_count_reg <= POINT_COUNT_W'(64);
            state_reg       <= S_IDLE;
            t_reg           <= '0;
            last_reg        <= IDX_ONE;
            k_reg           <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            m_reg           <= '0;
            n_reg           <= '0;
            found_reg       <= 1'b0;
            gm_reg          <= '0;
            den_mag_reg     <= '0;
            den_neg_reg     <= 1'b0;
            rem_reg         <= '0;
            dvd_reg         <= '0;
            qneg_reg        <= 1'b0;
            phase_reg       <= 1'b0;
            step_reg        <= '0;
            lw_reg          <= '0;
            done_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_m_reg       <= '0;
            out_n_reg       <= '0;
            out_lw_reg      <= '0;
            out_uw_reg      <= '0;
            out_bad_reg     <= 1'b0;
            res_uw_reg      <= '0;
            res_bad_reg     <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SUM_MODE:    sum_mode_reg    <= cfg_data[0];
                    CFG_POINT_COUNT: point_count_reg <= cfg_data;
                endcase
            end

            // finished result waits here until the output register is free
            if (done_pend_reg && out_free) begin
                out_valid_reg <= 1'b1;
                out_m_reg     <= m_reg;
                out_n_reg     <= n_reg;
                out_lw_reg    <= lw_reg;
                out_uw_reg    <= res_uw_reg;
                out_bad_reg   <= res_bad_reg;
                done_pend_reg <= 1'b0;
            end
            else if (response.ready) begin
                out_valid_reg <= 1'b0;
            end

            // scan compare on the word read in the previous cycle
            if (pend_reg) begin
                if (hit_le) begin
                    m_reg <= pend_idx_reg;
                end
                else if (!found_reg) begin
                    n_reg     <= pend_idx_reg;
                    found_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    if (in_fire && (request.command == CMD_QUERY)) begin
                        t_reg     <= t_target;
                        last_reg  <= last_init;
                        k_reg     <= '0;
                        m_reg     <= '0;
                        n_reg     <= last_init;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= 1'b1;
                    pend_idx_reg <= k_reg;
                    k_reg        <= k_reg + IDX_ONE;
                    if (k_reg == last_reg) begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    pend_reg  <= 1'b0;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (n_reg == '0) begin
                        n_reg <= IDX_ONE;
                    end
                    if (m_reg == last_reg) begin
                        m_reg <= last_reg - IDX_ONE;
                    end
                    state_reg <= S_RD_M;
                end
                S_RD_M:
                begin
                    state_reg <= S_RD_N;
                end
                S_RD_N:
                begin
                    gm_reg    <= rd_data_reg;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    if (den_c == '0) begin
                        lw_reg        <= '0;
                        res_uw_reg    <= '0;
                        res_bad_reg   <= 1'b1;
                        done_pend_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else begin
                        den_neg_reg <= den_c[MAG_W-1];
                        den_mag_reg <= den_c[MAG_W-1] ? VALUE_W'(-den_c) : VALUE_W'(den_c);
                        qneg_reg    <= num0[NUM_W-1] ^ den_c[MAG_W-1];
                        dvd_reg     <= {num_mag(num0), {FRAC_W{1'b0}}};
                        rem_reg     <= '0;
                        step_reg    <= '0;
                        phase_reg   <= 1'b0;
                        res_bad_reg <= 1'b0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        if (!phase_reg) begin
                            lw_reg    <= q_sat;
                            qneg_reg  <= num1[NUM_W-1] ^ !den_neg_reg;
                            dvd_reg   <= {num_mag(num1), {FRAC_W{1'b0}}};
                            rem_reg   <= '0;
                            step_reg  <= '0;
                            phase_reg <= 1'b1;
                        end
                        else begin
                            res_uw_reg    <= q_sat;
                            done_pend_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else begin
                        dvd_reg  <= dvd_next;
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_bad_zero_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.bad_grid)
        |-> (response.lower_weight == '0) && (response.upper_weight == '0))
        else $error("bad grid word with nonzero weights");

    a_distinct_indices: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && !response.bad_grid)
        |-> (response.lower_index != response.upper_index))
        else $error("good word with equal bracket indices");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.command == CMD_QUERY))
        |=> !request.ready)
        else $error("request ready right after a query");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.command == CMD_LOAD))
        |=> request.ready)
        else $error("load word stalled the request side");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divider step count out of range");

endmodule
